// File: src/cts_pkg.sv
package cts_pkg;

  // Field widths fixed by the interface.
  localparam int X_W        = 32;
  localparam int TERM_W     = 64;
  localparam int ACC_W      = 2 * TERM_W;
  localparam int IDX_W      = 6;
  localparam int TOL_W      = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int HALF_W     = TERM_W / 2;

  // x squared is kept as Q16.48, so the product drops 48 fraction bits.
  localparam int X2_FRAC    = 48;
  localparam int NUM_W      = ACC_W - X2_FRAC;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = NUM_W / DIV_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int MUL_STEPS  = 4;

  localparam int MAX_TERMS_DEF = 32;
  localparam int FRAC_BITS_DEF = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LIMIT = 2'd2;

  localparam logic [TOL_W-1:0] TOL_RESET   = 40'd10995;
  localparam logic [IDX_W-1:0] LIMIT_RESET = 6'd16;

  typedef struct packed {
    logic       load;
    logic       mul_sq;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_clr;
    logic       acc_en;
    logic       x2_wr;
    logic       div_ld_term;
    logic       div_ld_rem;
    logic       div_step;
    logic       term_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_lt_limit;
    logic stop_tol;
  } dp_stat_t;

endpackage

// File: src/cts_ctrl.sv
module cts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output cts_pkg::dp_cmd_t  cmd,
  input  cts_pkg::dp_stat_t stat
);
  import cts_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SQ   = 12'b0000_0000_0010,
    S_SQW  = 12'b0000_0000_0100,
    S_TEST = 12'b0000_0000_1000,
    S_MUL  = 12'b0000_0001_0000,
    S_MULW = 12'b0000_0010_0000,
    S_DLD  = 12'b0000_0100_0000,
    S_DIV  = 12'b0000_1000_0000,
    S_ACC  = 12'b0001_0000_0000,
    S_RLD  = 12'b0010_0000_0000,
    S_RDIV = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        cmd.mul_en = 1'b1;
        state_nxt  = S_SQW;
      end
      S_SQW: begin
        // The first term is never held against the tolerance.
        cmd.x2_wr = 1'b1;
        state_nxt = stat.idx_lt_limit ? S_MUL : S_RLD;
      end
      S_TEST: begin
        state_nxt = (stat.idx_lt_limit && !stat.stop_tol) ? S_MUL : S_RLD;
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt_r[1:0];
        cmd.acc_clr = (cnt_r == '0);
        cmd.acc_en  = (cnt_r != '0);
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = S_MULW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MULW: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_DLD;
      end
      S_DLD: begin
        cmd.div_ld_term = 1'b1;
        state_nxt       = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACC: begin
        cmd.term_upd = 1'b1;
        state_nxt    = S_TEST;
      end
      S_RLD: begin
        cmd.div_ld_rem = 1'b1;
        state_nxt      = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// File: src/cts_dpath.sv
module cts_dpath #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic signed [cts_pkg::X_W-1:0]    in_x_arg,
  input  cts_pkg::dp_cmd_t                  cmd,
  output cts_pkg::dp_stat_t                 stat,
  output logic [cts_pkg::TERM_W-1:0]        out_cosh_sum,
  output logic [cts_pkg::TERM_W-1:0]        out_remainder_est,
  output logic [cts_pkg::IDX_W-1:0]         out_terms_used,
  output logic                              out_overflow
);
  import cts_pkg::*;

  localparam int DMAX    = 2 * (MAX_TERMS - 1) * (2 * (MAX_TERMS - 1) - 1);
  localparam int DLOG    = $clog2(DMAX + 1);
  localparam int DIV_W   = (DLOG < 2) ? 2 : DLOG;
  localparam int TOL_LSH = (FRAC_BITS >= TOL_W) ? FRAC_BITS - TOL_W : 0;
  localparam int TOL_RSH = (FRAC_BITS >= TOL_W) ? 0 : TOL_W - FRAC_BITS;

  // Configuration registers.
  logic             stop_mode_r;
  logic [TOL_W-1:0] tol_r;
  logic [IDX_W-1:0] limit_r;

  // Series state and arithmetic registers.
  logic [HALF_W-1:0] ax_r;
  logic [TERM_W-1:0] x2_r;
  logic [TERM_W-1:0] term_r;
  logic [TERM_W-1:0] sum_r;
  logic [IDX_W-1:0]  idx_r;
  logic              ovf_r;
  logic [TERM_W-1:0] pp_r;
  logic [1:0]        pp_sh_r;
  logic [ACC_W-1:0]  acc_r;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  d_r;

  logic [HALF_W-1:0]    x_mag;
  logic [HALF_W-1:0]    mul_a, mul_b;
  logic [TERM_W-1:0]    prod;
  logic [ACC_W-1:0]     pp_shifted;
  logic [IDX_W:0]       k2;
  logic [2*IDX_W+1:0]   dprod;
  logic [TERM_W-1:0]    new_term;
  logic                 term_sat;
  logic [TERM_W:0]      sum_ext;
  logic [IDX_W-1:0]     eff_limit;
  logic [TERM_W-1:0]    tol_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_mode_r <= 1'b0;
      tol_r       <= TOL_RESET;
      limit_r     <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_MODE:  stop_mode_r <= cfg_wdata[0];
        CFG_TOLERANCE:  tol_r       <= cfg_wdata[TOL_W-1:0];
        CFG_TERM_LIMIT: limit_r     <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Two's complement magnitude; the most negative input maps to 2^31.
  assign x_mag = in_x_arg[X_W-1] ? (~in_x_arg + 1'b1) : in_x_arg;

  // One shared 32x32 multiplier: squares x, then forms four partial products per term.
  always_comb begin
    if (cmd.mul_sq) begin
      mul_a = ax_r;
      mul_b = ax_r;
    end else begin
      mul_a = cmd.mul_sel[0] ? term_r[TERM_W-1:HALF_W] : term_r[HALF_W-1:0];
      mul_b = cmd.mul_sel[1] ? x2_r[TERM_W-1:HALF_W]   : x2_r[HALF_W-1:0];
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = {{TERM_W{1'b0}}, pp_r};
      2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_r, {HALF_W{1'b0}}};
      2'd2:    pp_shifted = {pp_r, {TERM_W{1'b0}}};
      default: pp_shifted = '0;
    endcase
  end

  // Divisor 2k(2k-1) for the term being formed.
  assign k2    = {idx_r, 1'b0};
  assign dprod = k2 * (k2 - 1'b1);

  // Restoring division, DIV_BITS quotient bits per cycle; quotient shifts into num_r.
  always_comb begin : div_blk
    logic [DIV_W:0] r2;
    rem_nxt = rem_r;
    num_nxt = num_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2      = {rem_nxt, num_nxt[NUM_W-1]};
      num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
      if (r2 >= {1'b0, d_r}) begin
        r2         = r2 - {1'b0, d_r};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = r2[DIV_W-1:0];
    end
  end

  assign term_sat = |num_r[NUM_W-1:TERM_W];
  assign new_term = term_sat ? '1 : num_r[TERM_W-1:0];
  assign sum_ext  = {1'b0, sum_r} + {1'b0, new_term};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= x_mag;
      term_r <= TERM_W'(1) << FRAC_BITS;
      sum_r  <= TERM_W'(1) << FRAC_BITS;
      idx_r  <= IDX_W'(1);
      ovf_r  <= 1'b0;
    end
    if (cmd.mul_en) begin
      pp_r    <= prod;
      pp_sh_r <= 2'(cmd.mul_sel[0]) + 2'(cmd.mul_sel[1]);
    end
    if (cmd.x2_wr) begin
      x2_r <= pp_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + pp_shifted;
    end
    if (cmd.div_ld_term) begin
      num_r <= acc_r[ACC_W-1:X2_FRAC];
      rem_r <= '0;
      d_r   <= dprod[DIV_W-1:0];
    end else if (cmd.div_ld_rem) begin
      // Two thirds of the last term: floor(2t / 3).
      num_r <= NUM_W'({term_r, 1'b0});
      rem_r <= '0;
      d_r   <= DIV_W'(3);
    end else if (cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.term_upd) begin
      term_r <= new_term;
      sum_r  <= sum_ext[TERM_W] ? '1 : sum_ext[TERM_W-1:0];
      idx_r  <= idx_r + 1'b1;
      ovf_r  <= ovf_r | term_sat | sum_ext[TERM_W];
    end
  end

  always_comb begin
    if (limit_r == '0) begin
      eff_limit = IDX_W'(1);
    end else if (limit_r > IDX_W'(MAX_TERMS)) begin
      eff_limit = IDX_W'(MAX_TERMS);
    end else begin
      eff_limit = limit_r;
    end
  end

  assign tol_scaled = (TERM_W'(tol_r) << TOL_LSH) >> TOL_RSH;

  assign stat.idx_lt_limit = (idx_r < eff_limit);
  assign stat.stop_tol     = !stop_mode_r && (term_r <= tol_scaled);

  assign out_cosh_sum      = sum_r;
  assign out_remainder_est = num_r[TERM_W-1:0];
  assign out_terms_used    = idx_r;
  assign out_overflow      = ovf_r;

endmodule

// File: src/cosh_taylor_series.sv
// Channel   Transfer condition        Ports
// input     start & !busy             in_x_arg
// result    out_valid (one cycle)     out_cosh_sum, out_remainder_est, out_terms_used,
//                                     out_overflow
// config    cfg_we                    cfg_index, cfg_wdata
//
// For each further term, the partial products are formed on the shared 32x32 multiplier, the
// accumulation is finished, the divider is loaded and runs its radix-16 steps, and the sum
// is updated and the term tested. After the last term the divider forms the remainder estimate.
// Reset is synchronous and active low; it clears the controller and loads register defaults.
// The result is shown for exactly one cycle, and the receiver cannot stall it.
module cosh_taylor_series #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [cts_pkg::X_W-1:0] in_x_arg,
  output logic                           out_valid,
  output logic [cts_pkg::TERM_W-1:0]     out_cosh_sum,
  output logic [cts_pkg::TERM_W-1:0]     out_remainder_est,
  output logic [cts_pkg::IDX_W-1:0]      out_terms_used,
  output logic                           out_overflow,
  input  logic                           cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  cts_dpath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_x_arg          (in_x_arg),
    .cmd               (cmd),
    .stat              (stat),
    .out_cosh_sum      (out_cosh_sum),
    .out_remainder_est (out_remainder_est),
    .out_terms_used    (out_terms_used),
    .out_overflow      (out_overflow)
  );

endmodule

// File: src/cts_chk.sv
module cts_chk #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [cts_pkg::IDX_W-1:0] out_terms_used
);
  import cts_pkg::*;

  // A result only appears while an argument is being worked on.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a busy interval");

  // An accepted argument makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transfer did not start work");

  // After a result the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block still busy after result transfer");

  // The term count lies between one and the build limit.
  a_terms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_terms_used != '0 && out_terms_used <= IDX_W'(MAX_TERMS)))
    else $error("terms used out of range");

endmodule

bind cosh_taylor_series cts_chk #(.MAX_TERMS(MAX_TERMS)) u_cts_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_terms_used (out_terms_used)
);

// File: test/cts_checker.sv
`timescale 1ns / 100ps

module cts_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [cts_pkg::X_W-1:0]        in_x_arg,
  input  logic                           out_valid,
  input  logic [cts_pkg::TERM_W-1:0]     out_cosh_sum,
  input  logic [cts_pkg::TERM_W-1:0]     out_remainder_est,
  input  logic [cts_pkg::IDX_W-1:0]      out_terms_used,
  input  logic                           out_overflow,
  input  logic                           cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import cts_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic [X_W-1:0]    arg;
    logic [TERM_W-1:0] sum;
    logic [TERM_W-1:0] rem_est;
    logic [IDX_W-1:0]  terms;
    logic              ovf;
  } cosh_expect_t;

  cosh_expect_t      expected_q[$];
  int                mismatch_count = 0;
  logic              mode_copy;
  logic [TOL_W-1:0]  tol_copy;
  logic [IDX_W-1:0]  limit_copy;

  assign fail_count = mismatch_count;

  task automatic report_mismatch(input string what, input logic [X_W-1:0] arg,
                                 input logic [TERM_W-1:0] got,
                                 input logic [TERM_W-1:0] want);
    if (mismatch_count < 100)
      $display("%0t: %s mismatch for x=%h: got %h, expected %h",
               $realtime, what, arg, got, want);
    mismatch_count++;
  endtask

  // Sums the series for one argument under the given register values.
  function automatic cosh_expect_t sum_cosh_series(input logic [X_W-1:0] x,
                                                   input logic mode,
                                                   input logic [TOL_W-1:0] tol,
                                                   input logic [IDX_W-1:0] limit);
    logic [X_W-1:0]    mag;
    logic [TERM_W-1:0] x_sq;
    logic [TERM_W-1:0] term;
    logic [TERM_W-1:0] acc;
    logic [ACC_W-1:0]  prod;
    logic [NUM_W-1:0]  quot;
    logic [15:0]       denom;
    logic [TERM_W+1:0] twice;
    logic              sat;
    int                n_max;
    int                idx;
    cosh_expect_t      r;
    // Negating the most negative argument gives back 2^31, which is the magnitude.
    mag   = x[X_W-1] ? (~x + 1'b1) : x;
    x_sq  = {32'b0, mag} * {32'b0, mag};
    n_max = limit;
    if (n_max < 1) n_max = 1;
    if (n_max > MAX_TERMS_DEF) n_max = MAX_TERMS_DEF;
    term = 64'd1 << FRAC;
    acc  = term;
    sat  = 1'b0;
    idx  = 1;
    while (idx < n_max) begin
      denom = 16'(2 * idx * (2 * idx - 1));
      prod  = {64'b0, term} * {64'b0, x_sq};
      quot  = prod[ACC_W-1:X2_FRAC] / {64'b0, denom};
      if (quot[NUM_W-1:TERM_W] != '0) begin
        term = '1;
        sat  = 1'b1;
      end else begin
        term = quot[TERM_W-1:0];
      end
      if (acc > ~term) begin
        acc = '1;
        sat = 1'b1;
      end else begin
        acc = acc + term;
      end
      idx++;
      if (!mode && term <= {24'b0, tol}) break;
    end
    twice     = {1'b0, term, 1'b0};
    r.arg     = x;
    r.sum     = acc;
    r.rem_est = TERM_W'(twice / 3);
    r.terms   = IDX_W'(idx);
    r.ovf     = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    cosh_expect_t want;
    if (!rst_n) begin
      expected_q.delete();
      mode_copy  = 1'b0;
      tol_copy   = TOL_RESET;
      limit_copy = LIMIT_RESET;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_cosh_sum, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_cosh_sum !== want.sum)
            report_mismatch("cosh_sum", want.arg, out_cosh_sum, want.sum);
          if (out_remainder_est !== want.rem_est)
            report_mismatch("remainder_est", want.arg, out_remainder_est, want.rem_est);
          if (out_terms_used !== want.terms)
            report_mismatch("terms_used", want.arg, 64'(out_terms_used), 64'(want.terms));
          if (out_overflow !== want.ovf)
            report_mismatch("overflow", want.arg, 64'(out_overflow), 64'(want.ovf));
        end
      end
      if (start && !busy)
        expected_q.push_back(sum_cosh_series(in_x_arg, mode_copy, tol_copy, limit_copy));
      if (cfg_we) begin
        case (cfg_index)
          CFG_STOP_MODE:  mode_copy  = cfg_wdata[0];
          CFG_TOLERANCE:  tol_copy   = cfg_wdata[TOL_W-1:0];
          CFG_TERM_LIMIT: limit_copy = cfg_wdata[IDX_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
  end

endmodule

// File: test/tb_cosh_taylor_series.sv
`timescale 1ns / 100ps

module tb_cosh_taylor_series;
  import cts_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int STALL_LIMIT  = 4000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic [X_W-1:0]        in_x_arg  = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STOP_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  busy;
  logic                  out_valid;
  logic [TERM_W-1:0]     out_cosh_sum;
  logic [TERM_W-1:0]     out_remainder_est;
  logic [IDX_W-1:0]      out_terms_used;
  logic                  out_overflow;
  int                    fail_count;
  int                    pending;
  int                    stall_cycles = 0;

  always #5 clk = ~clk;

  cosh_taylor_series dut (
    .clk, .rst_n, .start, .busy, .in_x_arg,
    .out_valid, .out_cosh_sum, .out_remainder_est, .out_terms_used, .out_overflow,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  cts_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_x_arg,
    .out_valid, .out_cosh_sum, .out_remainder_est, .out_terms_used, .out_overflow,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Returns at the edge that accepts the argument, with start still high.
  // The idle gap is counted from the point where the block is free again.
  task automatic send_arg(input logic [X_W-1:0] x, input logic no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start    <= 1'b1;
    in_x_arg <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Upper bits of the narrow registers carry junk that the block must ignore.
  task automatic apply_config(input logic mode, input logic [TOL_W-1:0] tol,
                              input logic [IDX_W-1:0] limit, input logic [39:0] junk);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STOP_MODE;
    cfg_wdata <= {junk[39:1], mode};
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_index <= CFG_TERM_LIMIT;
    cfg_wdata <= {junk[39:6], limit};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small arguments, so tolerance mode ends early; a few reach the extremes.
  function automatic logic [X_W-1:0] rand_arg();
    logic [X_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
      5, 6:          v = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
      7:             v = $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: begin
        v = 32'h1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  initial begin
    int               sent;
    int               phase_len;
    logic             mode;
    logic             no_gaps;
    logic [TOL_W-1:0] tol;
    logic [IDX_W-1:0] limit;
    logic [63:0]      wide;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset: extremes and landmarks of the argument.
    send_arg(32'h0000_0000, 1'b0);
    send_arg(32'h0100_0000, 1'b0);
    send_arg(32'hFF00_0000, 1'b1);
    send_arg(32'h7FFF_FFFF, 1'b0);
    send_arg(32'h8000_0000, 1'b0);
    send_arg(32'h0000_0001, 1'b1);
    send_arg(32'hFFFF_FFFF, 1'b0);
    send_arg(32'h0080_0000, 1'b0);

    // A term limit of zero behaves as one, so only the leading term is summed.
    apply_config(1'b1, '0, 6'd0, '0);
    send_arg(32'h0100_0000, 1'b0);
    send_arg(32'h8000_0000, 1'b0);

    // A limit above the maximum is clamped; large arguments saturate.
    apply_config(1'b1, '0, 6'd63, '0);
    send_arg(32'h7FFF_FFFF, 1'b0);
    send_arg(32'h0200_0000, 1'b0);
    send_arg(32'hFE00_0000, 1'b0);

    // Zero tolerance only stops once a term truncates to zero.
    apply_config(1'b0, '0, 6'd32, '0);
    send_arg(32'h0000_0000, 1'b0);
    send_arg(32'h0000_0100, 1'b0);

    // The leading term is never tested, so the widest tolerance still sums two terms.
    apply_config(1'b0, '1, 6'd2, '0);
    send_arg(32'h0100_0000, 1'b0);
    send_arg(32'h1000_0000, 1'b0);

    apply_config(1'b1, 40'd10995, 6'd1, '0);
    send_arg(rand_arg(), 1'b0);
    send_arg(rand_arg(), 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = 1'($urandom_range(0, 1));
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0:       tol = '0;
        1:       tol = '1;
        2:       tol = wide[TOL_W-1:0];
        default: tol = TOL_W'($urandom_range(0, 32'h000F_FFFF));
      endcase
      case ($urandom_range(0, 9))
        0:       limit = 6'd0;
        1:       limit = 6'd63;
        2:       limit = 6'd32;
        3:       limit = 6'd1;
        4, 5:    limit = 6'($urandom_range(17, 32));
        default: limit = 6'($urandom_range(2, 16));
      endcase
      apply_config(mode, tol, limit, ($urandom_range(0, 3) == 0) ? wide[63:24] : 40'd0);
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 80);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        send_arg(rand_arg(), no_gaps);
        sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cts_pkg.sv
src/cts_ctrl.sv
src/cts_dpath.sv
src/cosh_taylor_series.sv
src/cts_chk.sv
test/cts_checker.sv
test/tb_cosh_taylor_series.sv
